// File: rtl/core/bpsc_pkg.sv
// Shared widths, reset values and status codes for the padding strip checker.
`timescale 1ns / 1ps
package bpsc_pkg;
  localparam int DATA_W         = 8;
  localparam int BS_W           = 6;
  localparam int HOLD_DEPTH_DEF = 32;
  localparam int APB_DW         = 32;
  localparam int APB_AW         = 3;
  localparam logic [BS_W-1:0] BS_RESET = BS_W'(16);
  localparam logic [0:0] REG_BLK_LEN = 1'b0;

  typedef enum logic [1:0] {
    PAD_STRIPPED  = 2'd0,
    PAD_BAD       = 2'd1,
    PAD_UNCHANGED = 2'd2
  } pad_status_t;
endpackage

// File: rtl/core/bpsc_if.sv
// Valid/ready stream interfaces for the byte input and the result output.
`timescale 1ns / 1ps
interface bpsc_in_if import bpsc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_byte;
  logic              last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface bpsc_out_if import bpsc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] out_byte;
  logic              data_valid;
  logic              out_last;
  logic [1:0]        pad_status;

  modport source (output valid, output out_byte, output data_valid, output out_last,
                  output pad_status, input ready);
  modport sink   (input valid, input out_byte, input data_valid, input out_last,
                  input pad_status, output ready);
endinterface

// File: rtl/core/bpsc_ring_ram.sv
// Holdback ring store: one write port, one registered read port.
`timescale 1ns / 1ps
module bpsc_ring_ram import bpsc_pkg::*; #(
  parameter int DEPTH = HOLD_DEPTH_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [AW-1:0]     raddr,
  output logic [DATA_W-1:0] rdata
);
  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

// File: rtl/core/bpsc_apb_regs.sv
// APB configuration register bank holding the block size.
`timescale 1ns / 1ps
module bpsc_apb_regs import bpsc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output logic [BS_W-1:0]   blk_len
);
  logic [BS_W-1:0] blk_len_r;
  logic [BS_W-1:0] blk_len_nxt;
  logic            hit;

  assign hit    = paddr[APB_AW-1] == REG_BLK_LEN;
  assign pready = 1'b1;

  always_comb begin
    blk_len_nxt = blk_len_r;
    if (psel && penable && pwrite && hit) begin
      blk_len_nxt = pwdata[BS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blk_len_r <= BS_RESET;
    end else begin
      blk_len_r <= blk_len_nxt;
    end
  end

  assign prdata  = hit ? APB_DW'(blk_len_r) : '0;
  assign blk_len = blk_len_r;
endmodule

// File: rtl/core/block_padding_strip_check_core.sv
// Top level: PKCS#7 pad strip and check over a byte stream with a holdback ring.
`timescale 1ns / 1ps
// Bytes enter one per beat and are written into a ring of HOLD_DEPTH entries; once the
// ring holds the effective block size, the oldest byte leaves through S_RD, S_LOAD and
// S_DEC via the one registered read port of the ring. An ordinary byte passes S_IDLE
// and S_DEC, then those three per byte it releases. The final byte passes S_IDLE and
// S_DEC, then S_CRD and S_CCMP per pad byte compared (one read and one compare per
// step, stopping at the first mismatch), then S_RD and S_LOAD per flushed byte, or
// S_STAT for a status-only beat when the whole message was pad. Result beats also
// wait while out_ch.ready stalls the output register; in_ch.ready is low throughout.
// pad_status on the last beat: stripped, bad padding, or unchanged.
module block_padding_strip_check_core import bpsc_pkg::*; #(
  parameter int HOLD_DEPTH = HOLD_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  bpsc_in_if.sink           in_ch,
  bpsc_out_if.source        out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);
  localparam int AW   = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
  localparam int CW   = $clog2(HOLD_DEPTH + 1);
  localparam int SW   = CW + 1;
  localparam int CMPW = (CW > DATA_W) ? CW : DATA_W;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_DEC  = 7'b0000010,
    S_RD   = 7'b0000100,
    S_LOAD = 7'b0001000,
    S_CRD  = 7'b0010000,
    S_CCMP = 7'b0100000,
    S_STAT = 7'b1000000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [AW-1:0]     head_r, head_nxt;
  logic [AW-1:0]     wpos_r, wpos_nxt;
  logic [AW-1:0]     p_r, p_nxt;
  logic [CW-1:0]     keep_r, keep_nxt;
  logic [CW-1:0]     i_r, i_nxt;
  logic [DATA_W-1:0] b_r, b_nxt;
  logic              last_r, last_nxt;
  logic              flush_r, flush_nxt;
  pad_status_t       status_r, status_nxt;
  logic              ov_r, ov_nxt;
  logic [DATA_W-1:0] ob_r, ob_nxt;
  logic              odv_r, odv_nxt;
  logic              olast_r, olast_nxt;
  pad_status_t       ost_r, ost_nxt;

  logic [BS_W-1:0]   blk_len;
  logic [CW-1:0]     eff, limit;
  logic [SW-1:0]     wsum;
  logic [AW-1:0]     wpos, hinc, pdec, raddr;
  logic [DATA_W-1:0] rdata;
  logic              accept, out_free, fin;

  bpsc_apb_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .blk_len (blk_len)
  );

  bpsc_ring_ram #(.DEPTH(HOLD_DEPTH), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (accept),
    .waddr (wpos),
    .wdata (in_ch.data_byte),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    if (blk_len == '0) begin
      eff   = CW'(1);
      limit = '0;
    end else if (int'(blk_len) > HOLD_DEPTH) begin
      eff   = CW'(HOLD_DEPTH);
      limit = CW'(HOLD_DEPTH);
    end else begin
      eff   = CW'(blk_len);
      limit = CW'(blk_len);
    end
  end

  assign wsum = SW'(head_r) + SW'(cnt_r);
  assign wpos = (wsum >= SW'(HOLD_DEPTH)) ? AW'(wsum - SW'(HOLD_DEPTH)) : AW'(wsum);
  assign hinc = (head_r == AW'(HOLD_DEPTH - 1)) ? '0 : head_r + AW'(1);
  assign pdec = (p_r == '0) ? AW'(HOLD_DEPTH - 1) : p_r - AW'(1);
  assign raddr = (state_r == S_CRD) ? p_r : head_r;

  assign in_ch.ready = state_r == S_IDLE;
  assign accept      = in_ch.valid && (state_r == S_IDLE);
  assign out_free    = !ov_r || out_ch.ready;
  assign fin         = flush_r && (keep_r == CW'(1));

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    head_nxt   = head_r;
    wpos_nxt   = wpos_r;
    p_nxt      = p_r;
    keep_nxt   = keep_r;
    i_nxt      = i_r;
    b_nxt      = b_r;
    last_nxt   = last_r;
    flush_nxt  = flush_r;
    status_nxt = status_r;
    ov_nxt     = ov_r && !out_ch.ready;
    ob_nxt     = ob_r;
    odv_nxt    = odv_r;
    olast_nxt  = olast_r;
    ost_nxt    = ost_r;

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          cnt_nxt   = cnt_r + CW'(1);
          wpos_nxt  = wpos;
          b_nxt     = in_ch.data_byte;
          last_nxt  = in_ch.last_byte;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (!last_r) begin
          flush_nxt = 1'b0;
          state_nxt = (cnt_r >= eff) ? S_RD : S_IDLE;
        end else begin
          flush_nxt = 1'b1;
          if (b_r != '0 && CMPW'(b_r) <= CMPW'(limit)) begin
            if (CMPW'(b_r) > CMPW'(cnt_r)) begin
              status_nxt = PAD_BAD;
              keep_nxt   = cnt_r;
              state_nxt  = S_RD;
            end else begin
              status_nxt = PAD_STRIPPED;
              p_nxt      = wpos_r;
              i_nxt      = CW'(b_r);
              state_nxt  = S_CRD;
            end
          end else begin
            status_nxt = PAD_UNCHANGED;
            keep_nxt   = cnt_r;
            state_nxt  = S_RD;
          end
        end
      end
      S_RD: begin
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          ob_nxt    = rdata;
          odv_nxt   = 1'b1;
          olast_nxt = fin;
          ost_nxt   = fin ? status_r : PAD_STRIPPED;
          head_nxt  = hinc;
          if (!flush_r) begin
            cnt_nxt   = cnt_r - CW'(1);
            state_nxt = S_DEC;
          end else if (fin) begin
            cnt_nxt   = '0;
            head_nxt  = '0;
            state_nxt = S_IDLE;
          end else begin
            keep_nxt  = keep_r - CW'(1);
            state_nxt = S_RD;
          end
        end
      end
      S_CRD: begin
        state_nxt = S_CCMP;
      end
      S_CCMP: begin
        if (rdata != b_r) begin
          status_nxt = PAD_BAD;
          keep_nxt   = cnt_r;
          state_nxt  = S_RD;
        end else if (i_r == CW'(1)) begin
          keep_nxt  = cnt_r - CW'(b_r);
          state_nxt = (cnt_r == CW'(b_r)) ? S_STAT : S_RD;
        end else begin
          i_nxt     = i_r - CW'(1);
          p_nxt     = pdec;
          state_nxt = S_CRD;
        end
      end
      S_STAT: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          ob_nxt    = '0;
          odv_nxt   = 1'b0;
          olast_nxt = 1'b1;
          ost_nxt   = status_r;
          cnt_nxt   = '0;
          head_nxt  = '0;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      head_r  <= '0;
      ov_r    <= 1'b0;
      last_r  <= 1'b0;
      flush_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      head_r  <= head_nxt;
      ov_r    <= ov_nxt;
      last_r  <= last_nxt;
      flush_r <= flush_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wpos_r   <= wpos_nxt;
    p_r      <= p_nxt;
    keep_r   <= keep_nxt;
    i_r      <= i_nxt;
    b_r      <= b_nxt;
    status_r <= status_nxt;
    ob_r     <= ob_nxt;
    odv_r    <= odv_nxt;
    olast_r  <= olast_nxt;
    ost_r    <= ost_nxt;
  end

  assign out_ch.valid      = ov_r;
  assign out_ch.out_byte   = ob_r;
  assign out_ch.data_valid = odv_r;
  assign out_ch.out_last   = olast_r;
  assign out_ch.pad_status = ost_r;
endmodule

// File: verif/bpsc_checker.sv
// Scoreboard for the padding strip checker: tracks block size, predicts released beats, compares.
`timescale 1ns / 1ps
module bpsc_checker import bpsc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  bpsc_in_if                in_ch,
  bpsc_out_if               out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output int unsigned       fail_count,
  output int unsigned       pending
);
  localparam logic [APB_AW-1:0] BS_ADDR = APB_AW'(4 * int'(REG_BLK_LEN));

  typedef struct {
    logic [DATA_W-1:0] data;
    logic              has_data;
    logic              last;
    pad_status_t       status;
  } release_t;

  release_t          due_q[$];
  logic [DATA_W-1:0] held_q[$];
  logic [BS_W-1:0]   blk_len;
  release_t          want;

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] exp_val);
    $display("%0t mismatch: %s, got %0h expected %0h", $realtime, what, got, exp_val);
    fail_count = fail_count + 1;
  endtask

  // Apply one accepted input beat to the holdback copy and queue the beats it releases.
  task automatic predict_release(input logic [DATA_W-1:0] b, input logic fin);
    int unsigned eff, limit, keep, held;
    pad_status_t st;
    eff   = (blk_len == 0) ? 1 : ((blk_len > HOLD_DEPTH_DEF) ? HOLD_DEPTH_DEF : blk_len);
    limit = (blk_len == 0) ? 0 : eff;
    held_q.push_back(b);
    if (!fin) begin
      while (held_q.size() >= eff)
        due_q.push_back('{held_q.pop_front(), 1'b1, 1'b0, PAD_STRIPPED});
    end else begin
      held = held_q.size();
      keep = held;
      st   = PAD_UNCHANGED;
      if (b >= 1 && b <= limit) begin
        if (b > held) begin
          st = PAD_BAD;
        end else begin
          st = PAD_STRIPPED;
          for (int i = 0; i < b; i++)
            if (held_q[held - 1 - i] != b) st = PAD_BAD;
          if (st == PAD_STRIPPED) keep = held - b;
        end
      end
      if (keep == 0) begin
        // whole message was pad: status-only beat
        due_q.push_back('{'0, 1'b0, 1'b1, st});
      end else begin
        for (int i = 0; i < keep; i++)
          due_q.push_back('{held_q[i], 1'b1, (i == keep - 1),
                             (i == keep - 1) ? st : PAD_STRIPPED});
      end
      held_q.delete();
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      due_q.delete();
      held_q.delete();
      blk_len    = BS_RESET;
      fail_count = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (due_q.size() == 0) begin
          report_mismatch("beat with nothing expected", out_ch.out_byte, '0);
        end else begin
          want = due_q.pop_front();
          if (out_ch.data_valid !== want.has_data)
            report_mismatch("data_valid", DATA_W'(out_ch.data_valid), DATA_W'(want.has_data));
          if (out_ch.out_byte !== want.data)
            report_mismatch("out_byte", out_ch.out_byte, want.data);
          if (out_ch.out_last !== want.last)
            report_mismatch("out_last", DATA_W'(out_ch.out_last), DATA_W'(want.last));
          if (out_ch.pad_status !== want.status)
            report_mismatch("pad_status", DATA_W'(out_ch.pad_status), DATA_W'(want.status));
        end
      end
      if (psel && penable && pwrite && pready && paddr == BS_ADDR)
        blk_len = pwdata[BS_W-1:0];
      if (in_ch.valid && in_ch.ready)
        predict_release(in_ch.data_byte, in_ch.last_byte);
    end
    pending <= due_q.size();
  end
endmodule

// File: verif/block_padding_strip_check_core_test.sv
// Testbench top: drives byte messages and block size writes into the padding strip checker.
`timescale 1ns / 1ps
module block_padding_strip_check_core_test;
  import bpsc_pkg::*;

  localparam int unsigned IDLE_LIMIT  = 2000;
  localparam int unsigned QUIET       = 16;
  localparam int unsigned TOTAL_BEATS = 450;
  localparam logic [APB_AW-1:0] BS_ADDR = APB_AW'(4 * int'(REG_BLK_LEN));

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              psel, penable, pwrite, pready;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata, prdata;
  int unsigned       fail_count, pending;
  int unsigned       idle_cycles = 0;
  int unsigned       stall_left = 0;
  int unsigned       beats_sent = 0;
  logic              calm = 1'b0;
  logic [DATA_W-1:0] msg_q[$];

  bpsc_in_if  in_ch ();
  bpsc_out_if out_ch ();

  block_padding_strip_check_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  bpsc_checker scoreboard (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #5 clk = ~clk;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else begin
      out_ch.ready <= 1'b1;
      if (!calm && $urandom_range(0, 99) < 30) stall_left <= pick_gap();
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_beat(input logic [DATA_W-1:0] b, input logic fin);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.last_byte <= fin;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    beats_sent++;
  endtask

  task automatic send_message();
    foreach (msg_q[i]) send_beat(msg_q[i], i == msg_q.size() - 1);
  endtask

  task automatic send_bytes(input logic [DATA_W-1:0] bytes[$]);
    msg_q = bytes;
    send_message();
  endtask

  // Wait until every predicted beat has left, then let the block settle.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (QUIET) @(posedge clk);
  endtask

  task automatic write_blk_len(input int unsigned val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= BS_ADDR;
    pwdata  <= APB_DW'(val);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Mostly well-formed padded messages; some broken, over-long, out of range or pure noise.
  task automatic build_message(input int unsigned bs);
    int unsigned eff, limit, len, pad, kind, spot;
    eff   = (bs == 0) ? 1 : ((bs > HOLD_DEPTH_DEF) ? HOLD_DEPTH_DEF : bs);
    limit = (bs == 0) ? 0 : eff;
    len   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2 * eff + 2) : $urandom_range(0, 4);
    kind  = $urandom_range(0, 99);
    msg_q.delete();
    if (kind >= 88 || limit == 0) begin
      repeat (len + 1) msg_q.push_back(8'($urandom_range(0, 255)));
    end else if (kind >= 78) begin
      pad = $urandom_range(0, 1) ? 0 : $urandom_range(limit + 1, 255);
      repeat (len) msg_q.push_back(8'($urandom_range(0, 255)));
      msg_q.push_back(8'(pad));
    end else if (kind >= 70 && limit >= 2) begin
      pad = $urandom_range(2, limit);
      repeat ($urandom_range(0, pad - 2)) msg_q.push_back(8'($urandom_range(0, 255)));
      msg_q.push_back(8'(pad));
    end else begin
      pad = $urandom_range(1, limit);
      repeat (len) msg_q.push_back(8'($urandom_range(0, 255)));
      repeat (pad) msg_q.push_back(8'(pad));
      if (kind >= 55 && pad >= 2) begin
        spot = msg_q.size() - 1 - $urandom_range(1, pad - 1);
        msg_q[spot] = 8'(pad ^ $urandom_range(1, 255));
      end
    end
  endtask

  initial begin
    int unsigned bs_list[$];
    int unsigned bs, phase;
    bs_list = '{1, 32, 63, 0, 2, 40, 7};
    phase = 0;
    in_ch.valid     <= 1'b0;
    in_ch.data_byte <= '0;
    in_ch.last_byte <= 1'b0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset block size: zero pad, pad out of range, pad longer than message,
    // good strip, all-pad message, bad pad
    send_bytes('{8'h00});
    send_bytes('{8'hff});
    send_bytes('{8'h05});
    send_bytes('{8'haa, 8'h55, 8'h02, 8'h02});
    send_bytes('{8'h03, 8'h03, 8'h03});
    send_bytes('{8'h11, 8'h01, 8'h02});
    drain();
    // block size zero accepts no pad
    write_blk_len(0);
    send_bytes('{8'h10, 8'h01});
    drain();
    // lowered mid-message before an ordinary beat
    write_blk_len(4);
    msg_q = '{8'h10, 8'h20, 8'h30};
    foreach (msg_q[i]) send_beat(msg_q[i], 1'b0);
    drain();
    write_blk_len(2);
    send_bytes('{8'h40, 8'h02});
    drain();
    // lowered mid-message before the final beat
    write_blk_len(5);
    msg_q = '{8'h10, 8'h20, 8'h30, 8'h40};
    foreach (msg_q[i]) send_beat(msg_q[i], 1'b0);
    drain();
    write_blk_len(1);
    send_bytes('{8'h01});
    drain();

    while (beats_sent < TOTAL_BEATS) begin
      if (phase < bs_list.size()) bs = bs_list[phase];
      else if ($urandom_range(0, 1)) bs = $urandom_range(1, 8);
      else bs = $urandom_range(0, 63);
      phase++;
      calm = ($urandom_range(0, 3) == 0);
      write_blk_len(bs);
      repeat ($urandom_range(2, 6)) begin
        build_message(bs);
        send_message();
      end
      drain();
    end
    calm = 1'b0;
    repeat (QUIET) @(posedge clk);

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

// File: sim.f
rtl/core/bpsc_pkg.sv
rtl/core/bpsc_if.sv
rtl/core/bpsc_ring_ram.sv
rtl/core/bpsc_apb_regs.sv
rtl/core/block_padding_strip_check_core.sv
verif/bpsc_checker.sv
verif/block_padding_strip_check_core_test.sv
